// ===== rtl/pap_pkg.sv =====
// Package for the phase accumulator with Park rotation.
// Holds the register map, sequencer codes, widths and the quarter-wave sine table.
// No dependencies.
`default_nettype none

package pap_pkg;

    localparam int SINE_ADDR_BITS = 10;
    localparam int SINE_N         = 1 << SINE_ADDR_BITS;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int ACC_W = 48;

    typedef logic signed [15:0] sine_rom_t [0:SINE_N];

    typedef enum logic [1:0] {
        REG_PHASE_GAIN    = 2'd0,
        REG_RATED_VOLTAGE = 2'd1,
        REG_RPM_PER_HZ    = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_STEP   = 4'd0,
        OP_MAG    = 4'd1,
        OP_RPM    = 4'd2,
        OP_VREF_A = 4'd3,
        OP_VREF_B = 4'd4,
        OP_ID_0   = 4'd5,
        OP_ID_1   = 4'd6,
        OP_IQ_0   = 4'd7,
        OP_IQ_1   = 4'd8,
        OP_VD_0   = 4'd9,
        OP_VD_1   = 4'd10,
        OP_VQ_0   = 4'd11,
        OP_VQ_1   = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_STORE,
        ST_ROM_SIN,
        ST_ROM_COS,
        ST_SIGN,
        ST_DONE
    } state_t;

    // Unsigned long division by compare and subtract, one quotient bit per pass.
    // It only runs while the sine table is being built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series to x^11 in Q30, rounded half up to Q15 and saturated.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t      rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint         sum;
        longint         v;
        for (int k = 0; k <= SINE_N; k++)
        begin
            x    = (longint'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 5; n++)
            begin
                term = div_u64((term * x2) >> 30,
                               longint'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (sum + 16384) >>> 15;
            if (v > 32767)
                v = 32767;
            rom[k] = v[15:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/phase_accumulator_park_rotation_top.sv =====
// Top level of the phase accumulator with Park rotation.
// Depends on pap_pkg for the register map, sequencer codes and sine table.
//
// Usage: one request per control tick enters on the input channel (in_valid,
// in_stall) carrying the frequency command, the voltage reference fraction and
// the stationary-frame current and voltage vectors. One result request leaves
// on the output channel (out_valid, out_stall) with the rotating voltage
// reference, the synchronous-frame current and voltage, the shaft speed and
// the updated phase.
// All multiplications share one bit-serial shift-and-add unit that consumes
// one bit of a 16-bit signed operand per cycle. Thirteen products are needed
// per request, each made of a load, the bit steps and a store, with the two
// sine table reads and the quadrant signs between the speed product and the
// rotation products, and a handover of the result at the end. The input
// stalls until the sequencer is back in idle after that handover.
// The result sits in an output register, so a new request is accepted and
// computed while the previous result still waits. If the receiver still
// stalls when the next result is finished, the sequencer holds it internally.
// Reset clears the phase to zero, loads the register defaults and drops
// out_valid. The sine table is a constant quarter-wave table read through a
// registered port, so there is no clearing pass after reset.
`default_nettype none

module phase_accumulator_park_rotation_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic signed [15:0] freq_cmd,
    input  wire logic signed [15:0] ref_fraction,
    input  wire logic signed [15:0] i_alpha,
    input  wire logic signed [15:0] i_beta,
    input  wire logic signed [15:0] v_alpha,
    input  wire logic signed [15:0] v_beta,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [15:0] vref_alpha,
    output logic signed [15:0] vref_beta,
    output logic signed [15:0] i_direct,
    output logic signed [15:0] i_quadrature,
    output logic signed [15:0] v_direct,
    output logic signed [15:0] v_quadrature,
    output logic signed [15:0] shaft_rpm,
    output logic      [31:0] phase_out
);
    import pap_pkg::*;

    // Configuration registers.
    logic [23:0] phase_gain_reg;
    logic [14:0] rated_voltage_reg;
    logic [15:0] rpm_per_hz_reg;

    // Sequencer.
    state_t state_reg, state_next;
    op_t    op_reg;
    logic [3:0] cnt_reg;

    // Captured request.
    logic signed [15:0] freq_reg, refr_reg, ia_reg, ib_reg, va_reg, vb_reg;

    // Serial multiplier.
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] a_sh_reg;
    logic        [15:0]      b_sh_reg;
    logic signed [ACC_W-1:0] sel_a;
    logic signed [15:0]      sel_b;
    logic                    sel_clear;
    logic signed [ACC_W-1:0] addend;

    // Working values.
    logic [31:0]        phase_reg;
    logic [16:0]        mag_reg;
    logic signed [15:0] s0_reg, c0_reg, sn_reg, cs_reg;
    logic signed [15:0] rpm_res_reg, vra_res_reg, vrb_res_reg;
    logic signed [15:0] id_res_reg, iq_res_reg, vd_res_reg, vq_res_reg;
    logic               out_valid_reg;

    logic [1:0]                quad;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [SINE_ADDR_BITS:0]   idx_c;
    logic signed [ACC_W-1:0]   acc_abs;
    logic                      in_accept;
    logic                      handover;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(signed'(32767)))
            return 16'sh7FFF;
        else if (v < -ACC_W'(signed'(32768)))
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [15:0] q15_round(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + ACC_W'(16384)) >>> 15;
        return sat16(t);
    endfunction

    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign handover  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign quad  = phase_reg[31:30];
    assign idx   = phase_reg[29 -: SINE_ADDR_BITS];
    assign idx_c = (SINE_ADDR_BITS + 1)'(SINE_N) - {1'b0, idx};
    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    // Register read and write.
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_PHASE_GAIN:    prdata = {8'd0, phase_gain_reg};
            REG_RATED_VOLTAGE: prdata = {17'd0, rated_voltage_reg};
            REG_RPM_PER_HZ:    prdata = {16'd0, rpm_per_hz_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_gain_reg    <= 24'd429497;
            rated_voltage_reg <= 15'd16384;
            rpm_per_hz_reg    <= 16'd7680;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_PHASE_GAIN:    phase_gain_reg    <= pwdata[23:0];
                REG_RATED_VOLTAGE: rated_voltage_reg <= pwdata[14:0];
                REG_RPM_PER_HZ:    rpm_per_hz_reg    <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    // Operand selection for each product of the sequence.
    always_comb
    begin
        sel_clear = 1'b1;
        case (op_reg)
            OP_STEP:
            begin
                sel_b = freq_reg;
                sel_a = ACC_W'(signed'({1'b0, phase_gain_reg}));
            end
            OP_MAG:
            begin
                sel_b = refr_reg;
                sel_a = ACC_W'(signed'({1'b0, rated_voltage_reg}));
            end
            OP_RPM:
            begin
                sel_b = freq_reg;
                sel_a = ACC_W'(signed'({1'b0, rpm_per_hz_reg}));
            end
            OP_VREF_A:
            begin
                sel_b = cs_reg;
                sel_a = ACC_W'(signed'({1'b0, mag_reg}));
            end
            OP_VREF_B:
            begin
                sel_b = sn_reg;
                sel_a = ACC_W'(signed'({1'b0, mag_reg}));
            end
            OP_ID_0:
            begin
                sel_b = cs_reg;
                sel_a = ACC_W'(ia_reg);
            end
            OP_ID_1:
            begin
                sel_b = sn_reg;
                sel_a = ACC_W'(ib_reg);
                sel_clear = 1'b0;
            end
            OP_IQ_0:
            begin
                sel_b = cs_reg;
                sel_a = ACC_W'(ib_reg);
            end
            OP_IQ_1:
            begin
                sel_b = -sn_reg;
                sel_a = ACC_W'(ia_reg);
                sel_clear = 1'b0;
            end
            OP_VD_0:
            begin
                sel_b = cs_reg;
                sel_a = ACC_W'(va_reg);
            end
            OP_VD_1:
            begin
                sel_b = sn_reg;
                sel_a = ACC_W'(vb_reg);
                sel_clear = 1'b0;
            end
            OP_VQ_0:
            begin
                sel_b = cs_reg;
                sel_a = ACC_W'(vb_reg);
            end
            OP_VQ_1:
            begin
                sel_b = -sn_reg;
                sel_a = ACC_W'(va_reg);
                sel_clear = 1'b0;
            end
            default:
            begin
                sel_b = 16'sd0;
                sel_a = '0;
            end
        endcase
    end

    // The top bit of the signed multiplier carries negative weight.
    always_comb
    begin
        if (!b_sh_reg[0])
            addend = '0;
        else if (cnt_reg == 4'd15)
            addend = -a_sh_reg;
        else
            addend = a_sh_reg;
    end

    // State register and next-state logic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_accept) state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_MUL;
            ST_MUL:     if (cnt_reg == 4'd15) state_next = ST_STORE;
            ST_STORE:
            begin
                if (op_reg == OP_RPM)
                    state_next = ST_ROM_SIN;
                else if (op_reg == OP_VQ_1)
                    state_next = ST_DONE;
                else
                    state_next = ST_LOAD;
            end
            ST_ROM_SIN: state_next = ST_ROM_COS;
            ST_ROM_COS: state_next = ST_SIGN;
            ST_SIGN:    state_next = ST_LOAD;
            ST_DONE:    if (handover) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control counters, phase and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_STEP;
            cnt_reg       <= 4'd0;
            phase_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                op_reg <= OP_STEP;
            else if (state_reg == ST_STORE && op_reg != OP_RPM && op_reg != OP_VQ_1)
                op_reg <= op_t'(op_reg + 4'd1);
            else if (state_reg == ST_SIGN)
                op_reg <= OP_VREF_A;

            if (state_reg == ST_LOAD)
                cnt_reg <= 4'd0;
            else if (state_reg == ST_MUL)
                cnt_reg <= cnt_reg + 4'd1;

            if (state_reg == ST_STORE && op_reg == OP_STEP)
                phase_reg <= phase_reg + acc_reg[39:8];

            if (handover)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            freq_reg <= freq_cmd;
            refr_reg <= ref_fraction;
            ia_reg   <= i_alpha;
            ib_reg   <= i_beta;
            va_reg   <= v_alpha;
            vb_reg   <= v_beta;
        end

        case (state_reg)
            ST_LOAD:
            begin
                a_sh_reg <= sel_a;
                b_sh_reg <= sel_b;
                if (sel_clear)
                    acc_reg <= '0;
            end
            ST_MUL:
            begin
                acc_reg  <= acc_reg + addend;
                a_sh_reg <= a_sh_reg <<< 1;
                b_sh_reg <= b_sh_reg >> 1;
            end
            ST_STORE:
            begin
                case (op_reg)
                    OP_MAG:    mag_reg     <= acc_abs[30:14];
                    OP_RPM:    rpm_res_reg <= sat16((acc_reg + ACC_W'(32768)) >>> 16);
                    OP_VREF_A: vra_res_reg <= q15_round(acc_reg);
                    OP_VREF_B: vrb_res_reg <= q15_round(acc_reg);
                    OP_ID_1:   id_res_reg  <= q15_round(acc_reg);
                    OP_IQ_1:   iq_res_reg  <= q15_round(acc_reg);
                    OP_VD_1:   vd_res_reg  <= q15_round(acc_reg);
                    OP_VQ_1:   vq_res_reg  <= q15_round(acc_reg);
                    default:   ;
                endcase
            end
            ST_ROM_SIN: s0_reg <= SINE_ROM[idx];
            ST_ROM_COS: c0_reg <= SINE_ROM[idx_c];
            ST_SIGN:
            begin
                case (quad)
                    2'd0:
                    begin
                        sn_reg <= s0_reg;
                        cs_reg <= c0_reg;
                    end
                    2'd1:
                    begin
                        sn_reg <= c0_reg;
                        cs_reg <= -s0_reg;
                    end
                    2'd2:
                    begin
                        sn_reg <= -s0_reg;
                        cs_reg <= -c0_reg;
                    end
                    default:
                    begin
                        sn_reg <= -c0_reg;
                        cs_reg <= s0_reg;
                    end
                endcase
            end
            default: ;
        endcase

        if (handover)
        begin
            vref_alpha   <= vra_res_reg;
            vref_beta    <= vrb_res_reg;
            i_direct     <= id_res_reg;
            i_quadrature <= iq_res_reg;
            v_direct     <= vd_res_reg;
            v_quadrature <= vq_res_reg;
            shaft_rpm    <= rpm_res_reg;
            phase_out    <= phase_reg;
        end
    end

    // The phase moves only when the phase step product is stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_STORE && op_reg == OP_STEP) |=> $stable(phase_reg))
        else $error("phase changed outside the phase step store");

    // A new result is raised only from the handover state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("out_valid rose outside handover");

    // An accepted request starts the product sequence with the phase step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_LOAD && op_reg == OP_STEP))
        else $error("sequence did not start at the phase step");

endmodule

`default_nettype wire

// ===== bench/phase_accumulator_park_rotation_top_tb.sv =====
// Self-checking testbench for the phase accumulator with Park rotation.
// A queue-fed driver, a checking monitor and an APB writer exercise the block.
// Depends on pap_pkg for the register indexes and on the top level RTL.
`timescale 1ns / 1ps

module phase_accumulator_park_rotation_top_tb;

    import pap_pkg::*;

    localparam int ROM_BITS = 10;
    localparam int ROM_LEN  = 1 << ROM_BITS;

    // One control tick request as it enters the block.
    typedef struct {
        logic signed [15:0] freq;
        logic signed [15:0] refr;
        logic signed [15:0] ia;
        logic signed [15:0] ib;
        logic signed [15:0] va;
        logic signed [15:0] vb;
    } tick_req_t;

    // The outputs that one tick produces.
    typedef struct {
        logic signed [15:0] vref_a;
        logic signed [15:0] vref_b;
        logic signed [15:0] id;
        logic signed [15:0] iq;
        logic signed [15:0] vd;
        logic signed [15:0] vq;
        logic signed [15:0] rpm;
        logic        [31:0] phase;
    } tick_out_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] freq_cmd;
    logic signed [15:0] ref_fraction;
    logic signed [15:0] i_alpha;
    logic signed [15:0] i_beta;
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] vref_alpha;
    logic signed [15:0] vref_beta;
    logic signed [15:0] i_direct;
    logic signed [15:0] i_quadrature;
    logic signed [15:0] v_direct;
    logic signed [15:0] v_quadrature;
    logic signed [15:0] shaft_rpm;
    logic [31:0] phase_out;

    phase_accumulator_park_rotation_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .freq_cmd(freq_cmd), .ref_fraction(ref_fraction),
        .i_alpha(i_alpha), .i_beta(i_beta), .v_alpha(v_alpha), .v_beta(v_beta),
        .out_valid(out_valid), .out_stall(out_stall),
        .vref_alpha(vref_alpha), .vref_beta(vref_beta),
        .i_direct(i_direct), .i_quadrature(i_quadrature),
        .v_direct(v_direct), .v_quadrature(v_quadrature),
        .shaft_rpm(shaft_rpm), .phase_out(phase_out)
    );

    // Pending requests waiting for the driver, and the outputs the model
    // expects the block to produce, oldest first.
    tick_req_t pending_ticks[$];
    tick_out_t expected_outs[$];

    // The model's own copy of the registers and the phase accumulator.
    logic [23:0] gain_model;
    logic [14:0] rated_model;
    logic [15:0] rpm_model;
    logic [31:0] phase_model;
    int          sine_tab [0:ROM_LEN];

    int  errors;
    bit  idle_en;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    bit  long_hold_req;

    always #5 clk = ~clk;

    // The quarter-wave table: a Taylor series to x^11 in Q30, each term
    // truncated, then rounded half up to Q15 and clamped to full scale.
    function automatic void fill_sine_tab();
        longint unsigned x;
        longint unsigned xsq;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= ROM_LEN; k++)
        begin
            x    = (longint'(k) * 64'd1686629713) >> ROM_BITS;
            xsq  = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 5; n++)
            begin
                term = ((term * xsq) >> 30) / longint'(4 * n * n + 2 * n);
                acc  = (n % 2) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            acc = (acc + 16384) >>> 15;
            sine_tab[k] = (acc > 32767) ? 32767 : int'(acc);
        end
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] round_q15(longint v);
        return clamp16((v + 16384) >>> 15);
    endfunction

    // Advances the model phase and forms every output of one tick.
    function automatic tick_out_t rotate_tick(tick_req_t t);
        tick_out_t r;
        longint    step;
        longint    mag;
        longint    sn;
        longint    cs;
        int        s0;
        int        c0;
        logic [9:0] idx;
        step        = longint'(t.freq) * longint'(gain_model);
        phase_model = phase_model + step[39:8];
        idx         = phase_model[29:20];
        s0          = sine_tab[idx];
        c0          = sine_tab[ROM_LEN - idx];
        case (phase_model[31:30])
            2'd0:    begin sn = s0;  cs = c0;  end
            2'd1:    begin sn = c0;  cs = -s0; end
            2'd2:    begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0;  end
        endcase
        mag = longint'(rated_model) * longint'(t.refr);
        if (mag < 0)
            mag = -mag;
        mag      = mag >>> 14;
        r.vref_a = round_q15(mag * cs);
        r.vref_b = round_q15(mag * sn);
        r.id     = round_q15(cs * t.ia + sn * t.ib);
        r.iq     = round_q15(-sn * t.ia + cs * t.ib);
        r.vd     = round_q15(cs * t.va + sn * t.vb);
        r.vq     = round_q15(-sn * t.va + cs * t.vb);
        r.rpm    = clamp16((longint'(t.freq) * longint'(rpm_model) + 32768) >>> 16);
        r.phase  = phase_model;
        return r;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Sender: a request that was accepted at this edge goes through the model,
    // then the next one is offered, after a random gap while idle_en is set. The
    // payload is only changed when the current request is not stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_outs.push_back(rotate_tick('{freq_cmd, ref_fraction,
                    i_alpha, i_beta, v_alpha, v_beta}));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    tick_req_t t;
                    t = pending_ticks.pop_front();
                    freq_cmd     <= t.freq;
                    ref_fraction <= t.refr;
                    i_alpha      <= t.ia;
                    i_beta       <= t.ib;
                    v_alpha      <= t.va;
                    v_beta       <= t.vb;
                    in_valid     <= 1'b1;
                    send_gap = idle_en ? $urandom_range(0, 3) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted result against the oldest expectation
    // and decides its stall for the next cycle. A long hold-off, once asked
    // for, is counted down here so the block backs up into its input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outs.size() == 0)
                begin
                    $error("result request with nothing expected");
                    errors++;
                end
                else
                begin
                    tick_out_t e;
                    e = expected_outs.pop_front();
                    check_field("vref_alpha", e.vref_a, vref_alpha);
                    check_field("vref_beta", e.vref_b, vref_beta);
                    check_field("i_direct", e.id, i_direct);
                    check_field("i_quadrature", e.iq, i_quadrature);
                    check_field("v_direct", e.vd, v_direct);
                    check_field("v_quadrature", e.vq, v_quadrature);
                    check_field("shaft_rpm", e.rpm, shaft_rpm);
                    check_field("phase_out", e.phase, phase_out);
                end
                recv_gap = idle_en ? $urandom_range(0, 3) : 0;
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Register write: setup cycle, then the access cycle that commits it.
    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PHASE_GAIN:    gain_model  = value[23:0];
            REG_RATED_VOLTAGE: rated_model = value[14:0];
            REG_RPM_PER_HZ:    rpm_model   = value[15:0];
            default:           ;
        endcase
    endtask

    // Waits until every request has gone through and every result has come
    // back, then lets the sequencer settle before registers change.
    task automatic wait_drained();
        while (pending_ticks.size() > 0 || expected_outs.size() > 0 || in_valid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic add_tick(int f, int rf, int ia, int ib, int va, int vb);
        pending_ticks.push_back('{f[15:0], rf[15:0], ia[15:0], ib[15:0],
            va[15:0], vb[15:0]});
    endtask

    // Random ticks: mostly in-range reference fractions and moderate
    // frequencies, with a share of raw 16-bit values for saturation.
    task automatic add_random_ticks(int count);
        int f;
        int rf;
        for (int i = 0; i < count; i++)
        begin
            f  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000) - 2000;
            rf = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32768) - 16384;
            add_tick(f, rf, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        freq_cmd = '0;
        ref_fraction = '0;
        i_alpha = '0;
        i_beta = '0;
        v_alpha = '0;
        v_beta = '0;
        errors = 0;
        idle_en = 1'b1;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        long_hold_req = 1'b0;
        gain_model = 24'd429497;
        rated_model = 15'd16384;
        rpm_model = 16'd7680;
        phase_model = '0;
        fill_sine_tab();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks on the reset defaults: zero and full-scale fields,
        // reference fractions at and beyond plus and minus one.
        add_tick(0, 0, 0, 0, 0, 0);
        add_tick(32767, 16384, 32767, 32767, 32767, 32767);
        add_tick(-32768, -16384, -32768, -32768, -32768, -32768);
        add_tick(32767, 32767, 32767, -32768, -32768, 32767);
        add_tick(-32768, -32768, -32768, 32767, 32767, -32768);
        add_tick(256, 16384, 16384, 0, 0, 16384);
        add_tick(-256, -16384, 0, -16384, -16384, 0);
        add_tick(1, 1, 1, 1, 1, 1);
        add_tick(-1, -1, -1, -1, -1, -1);
        wait_drained();

        // Largest gain so the phase wraps within a few ticks, full-scale
        // rated voltage and rpm factor; a write to the unused index is ignored.
        reg_write(REG_PHASE_GAIN, 32'hFFFFFF);
        reg_write(REG_RATED_VOLTAGE, 32'h7FFF);
        reg_write(REG_RPM_PER_HZ, 32'hFFFF);
        reg_write(REG_UNUSED, 32'hFFFFFFFF);
        for (int i = 0; i < 6; i++)
            add_tick(32767, 16384, 32767, -32768, 12345, -12345);
        for (int i = 0; i < 6; i++)
            add_tick(-32768, -32768, -32768, 32767, -1, 1);
        wait_drained();

        // Random phases over several settings, both extremes among them.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin
                    reg_write(REG_PHASE_GAIN, 0);
                    reg_write(REG_RATED_VOLTAGE, 0);
                    reg_write(REG_RPM_PER_HZ, 0);
                end
                1: begin
                    reg_write(REG_PHASE_GAIN, 32'd429497);
                    reg_write(REG_RATED_VOLTAGE, 32'd16384);
                    reg_write(REG_RPM_PER_HZ, 32'd7680);
                end
                2: begin
                    reg_write(REG_PHASE_GAIN, 32'hFFFFFF);
                    reg_write(REG_RATED_VOLTAGE, 32'h7FFF);
                    reg_write(REG_RPM_PER_HZ, 32'hFFFF);
                end
                default: begin
                    reg_write(REG_PHASE_GAIN, $urandom_range(0, 24'hFFFFFF));
                    reg_write(REG_RATED_VOLTAGE, $urandom_range(0, 15'h7FFF));
                    reg_write(REG_RPM_PER_HZ, $urandom_range(0, 16'hFFFF));
                    reg_write(REG_UNUSED, $urandom);
                end
            endcase
            idle_en = (p != 1);
            // Back the block up once: the receiver holds off while requests
            // keep coming, so the input side must stall.
            if (p == 3)
                long_hold_req = 1'b1;
            add_random_ticks(245);
            wait_drained();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
